FILE: src/cct_pkg.sv
package cct_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2
    } t_cct_op;

    typedef enum logic {
        REG_MIN_YEAR = 1'b0,
        REG_MAX_YEAR = 1'b1
    } t_cct_reg;

    typedef struct packed {
        t_cct_op     opcode;
        logic [11:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } t_cct_in;

    typedef struct packed {
        logic [11:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [2:0]  cur_weekday;
        logic        set_rejected;
    } t_cct_out;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cct_time;

    typedef struct packed {
        t_cct_time tm;
        logic      rejected;
    } t_cct_stamp;

    typedef struct packed {
        logic [11:0] min_year;
        logic [11:0] max_year;
    } t_cct_cfg;

    localparam logic [11:0] MIN_YEAR_RESET = 12'd2000;
    localparam logic [11:0] MAX_YEAR_RESET = 12'd2099;

    localparam logic [11:0] YEAR_RESET   = 12'd2015;
    localparam logic [3:0]  MONTH_RESET  = 4'd1;
    localparam logic [4:0]  DAY_RESET    = 5'd1;

    localparam logic [5:0]  SECOND_LAST  = 6'd59;
    localparam logic [5:0]  MINUTE_LAST  = 6'd59;
    localparam logic [4:0]  HOUR_LAST    = 5'd23;
    localparam logic [4:0]  HOUR_SET_MAX = 5'd24;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;

    localparam logic [12:0] YEAR_OFFSET  = 13'd400;
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [13:0] RECIP_7      = 14'd9363;
    localparam int          RECIP_7_SH   = 16;
    localparam logic [12:0] DAYS_A_WEEK  = 13'd7;

endpackage

FILE: src/cct_time_core.sv
module cct_time_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cct_pkg::t_cct_cfg   i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  cct_pkg::t_cct_in    i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output cct_pkg::t_cct_stamp o_stamp
);
    import cct_pkg::*;

    logic [11:0] r_year,   n_year;
    logic [3:0]  r_month,  n_month;
    logic [4:0]  r_day,    n_day;
    logic [4:0]  r_hour,   n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic        r_rejected, n_rejected;
    logic        r_valid;
    logic        w_fire;
    logic        w_bad_set;

    function automatic logic is_leap(input logic [11:0] y);
        logic century_common;
        century_common = 1'b0;
        for (int k = 1; k <= 40; k++) begin
            if ((k % 4) != 0 && y == 12'(k * 100)) begin
                century_common = 1'b1;
            end
        end
        return (y[1:0] == 2'b00) && !century_common;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [3:0] k;
        k = (m > 4'd7) ? 4'(m - 4'd7) : m;
        if (m == 4'd2) begin
            return leap ? 5'd29 : 5'd28;
        end
        return 5'd30 + {4'd0, k[0]};
    endfunction

    assign o_ready  = !r_valid || i_ready;
    assign w_fire   = i_valid && o_ready;
    assign w_bad_set = (i_item.set_year < i_cfg.min_year)
                    || (i_item.set_year > i_cfg.max_year)
                    || (i_item.set_month > MONTH_LAST)
                    || (i_item.set_hour > HOUR_SET_MAX);

    always_comb begin
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_second   = r_second;
        n_rejected = 1'b0;
        unique case (i_item.opcode)
            OP_TICK: begin
                if (r_second < SECOND_LAST) begin
                    n_second = r_second + 6'd1;
                end else begin
                    n_second = '0;
                    if (r_minute < MINUTE_LAST) begin
                        n_minute = r_minute + 6'd1;
                    end else begin
                        n_minute = '0;
                        if (r_hour < HOUR_LAST) begin
                            n_hour = r_hour + 5'd1;
                        end else begin
                            n_hour = '0;
                            if (r_day < month_length(r_month, is_leap(r_year))) begin
                                n_day = r_day + 5'd1;
                            end else begin
                                n_day = 5'd1;
                                if (r_month < MONTH_LAST) begin
                                    n_month = r_month + 4'd1;
                                end else begin
                                    n_month = 4'd1;
                                    n_year  = r_year + 12'd1;
                                end
                            end
                        end
                    end
                end
            end
            OP_SET: begin
                if (w_bad_set) begin
                    n_rejected = 1'b1;
                end else begin
                    n_year   = i_item.set_year;
                    n_month  = i_item.set_month;
                    n_day    = i_item.set_day;
                    n_hour   = i_item.set_hour;
                    n_minute = i_item.set_minute;
                    n_second = i_item.set_second;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_year     <= YEAR_RESET;
            r_month    <= MONTH_RESET;
            r_day      <= DAY_RESET;
            r_hour     <= '0;
            r_minute   <= '0;
            r_second   <= '0;
            r_rejected <= 1'b0;
        end else begin
            if (w_fire) begin
                r_valid    <= 1'b1;
                r_year     <= n_year;
                r_month    <= n_month;
                r_day      <= n_day;
                r_hour     <= n_hour;
                r_minute   <= n_minute;
                r_second   <= n_second;
                r_rejected <= n_rejected;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_stamp.tm.year    = r_year;
    assign o_stamp.tm.month   = r_month;
    assign o_stamp.tm.day     = r_day;
    assign o_stamp.tm.hour    = r_hour;
    assign o_stamp.tm.minute  = r_minute;
    assign o_stamp.tm.second  = r_second;
    assign o_stamp.rejected   = r_rejected;

endmodule

FILE: src/cct_weekday.sv
module cct_weekday (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cct_pkg::t_cct_stamp i_stamp,
    output logic                o_valid,
    input  logic                i_ready,
    output cct_pkg::t_cct_out   o_data
);
    import cct_pkg::*;

    logic        r_s2_valid, r_s3_valid, r_out_valid;
    t_cct_stamp  r_s2_stamp, r_s3_stamp;
    logic [12:0] r_yy;
    logic [6:0]  r_q100;
    logic [5:0]  r_dm;
    logic [12:0] r_sum;
    t_cct_out    r_out;

    logic        w_out_ready, w_s3_ready, w_s2_ready;
    logic        w_jan_feb;
    logic [12:0] w_yy;
    logic [25:0] w_p100;
    logic [12:0] w_sum;
    logic [26:0] w_p7;
    logic [10:0] w_q7;
    logic [12:0] w_rem;

    // Month contribution 2*m + floor(3*(m+1)/5), reduced modulo 7, with
    // January and February counted as months 13 and 14.
    function automatic logic [2:0] month_term(input logic [3:0] m);
        logic [2:0] t;
        unique case (m)
            4'd0:    t = 3'd0;
            4'd1:    t = 3'd6;
            4'd2:    t = 3'd2;
            4'd3:    t = 3'd1;
            4'd4:    t = 3'd4;
            4'd5:    t = 3'd6;
            4'd6:    t = 3'd2;
            4'd7:    t = 3'd4;
            4'd8:    t = 3'd0;
            4'd9:    t = 3'd3;
            4'd10:   t = 3'd5;
            4'd11:   t = 3'd1;
            4'd12:   t = 3'd3;
            4'd13:   t = 3'd6;
            4'd14:   t = 3'd2;
            default: t = 3'd4;
        endcase
        return t;
    endfunction

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_s3_ready  = !r_s3_valid || w_out_ready;
    assign w_s2_ready  = !r_s2_valid || w_s3_ready;
    assign o_ready     = w_s2_ready;

    assign w_jan_feb = (i_stamp.tm.month == 4'd1) || (i_stamp.tm.month == 4'd2);
    assign w_yy      = 13'({1'b0, i_stamp.tm.year}) + YEAR_OFFSET - 13'({12'd0, w_jan_feb});
    assign w_p100    = 26'(w_yy) * 26'(RECIP_100);

    assign w_sum = r_yy + (r_yy >> 2) - 13'(r_q100) + 13'(r_q100 >> 2) + 13'(r_dm);

    assign w_p7  = 27'(r_sum) * 27'(RECIP_7);
    assign w_q7  = 11'(w_p7 >> RECIP_7_SH);
    assign w_rem = r_sum - 13'(13'(w_q7) * DAYS_A_WEEK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s2_ready) begin
                r_s2_valid <= i_valid;
            end
            if (w_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && i_valid) begin
            r_s2_stamp <= i_stamp;
            r_yy       <= w_yy;
            r_q100     <= 7'(w_p100 >> RECIP_100_SH);
            r_dm       <= 6'(i_stamp.tm.day) + 6'(month_term(i_stamp.tm.month));
        end
        if (w_s3_ready && r_s2_valid) begin
            r_s3_stamp <= r_s2_stamp;
            r_sum      <= w_sum;
        end
        if (w_out_ready && r_s3_valid) begin
            r_out.cur_year     <= r_s3_stamp.tm.year;
            r_out.cur_month    <= r_s3_stamp.tm.month;
            r_out.cur_day      <= r_s3_stamp.tm.day;
            r_out.cur_hour     <= r_s3_stamp.tm.hour;
            r_out.cur_minute   <= r_s3_stamp.tm.minute;
            r_out.cur_second   <= r_s3_stamp.tm.second;
            r_out.cur_weekday  <= w_rem[2:0];
            r_out.set_rejected <= r_s3_stamp.rejected;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: src/calendar_clock_tick.sv
// Calendar clock with Gregorian leap years and a day-of-week output.
// Input channel (i_in_valid / o_in_ready, payload i_in_data): each transfer
// carries one operation, a one-second tick, a set of the full date and
// time, or a read. Every input transfer yields exactly one result transfer
// on the output channel (o_out_valid / i_out_ready, payload o_out_data)
// with the date and time after the operation, the weekday (0 is Monday)
// and a flag that marks a refused set.
// One item is taken every cycle while the output channel does not stall.
// The input transfer is registered first; the clock registers are updated in the second
// stage; the weekday takes three more stages, one reciprocal multiply each
// for the divide by 100 and the remainder by 7, and drives o_out_valid.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes the smallest or largest year that a set accepts.
// Reset gives 2015-01-01 00:00:00, a Thursday, and a year range of
// 2000 to 2099, with an empty pipeline.
// When the receiver stalls, results stay in the stages; up to five items
// are held before o_in_ready drops.
module calendar_clock_tick (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cct_pkg::t_cct_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cct_pkg::t_cct_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  cct_pkg::t_cct_reg i_cfg_index,
    input  logic [11:0]       i_cfg_data
);
    import cct_pkg::*;

    logic       r_in_valid;
    t_cct_in    r_in;
    t_cct_cfg   r_cfg;
    logic       w_core_ready;
    logic       w_core_valid;
    t_cct_stamp w_stamp;
    logic       w_wd_ready;

    assign o_in_ready  = !r_in_valid || w_core_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_cfg.min_year <= MIN_YEAR_RESET;
            r_cfg.max_year <= MAX_YEAR_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MIN_YEAR: r_cfg.min_year <= i_cfg_data;
                    REG_MAX_YEAR: r_cfg.max_year <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    cct_time_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r_in_valid),
        .o_ready (w_core_ready),
        .i_item  (r_in),
        .o_valid (w_core_valid),
        .i_ready (w_wd_ready),
        .o_stamp (w_stamp)
    );

    cct_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_core_valid),
        .o_ready (w_wd_ready),
        .i_stamp (w_stamp),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
